FILE: sv/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and character helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DEC_BITS        = 32;
    localparam int DEC_DIGITS      = 10;
    localparam int COUNT_W         = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // command codes
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEXL = 3'd2;
    localparam logic [2:0] CMD_HEXU = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } t_prefix;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (d < 4'd10) begin
            digit_char = 8'h30 + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

    function automatic logic [2:0] prefix_len(input t_prefix p);
        case (p)
            PFX_MINUS: prefix_len = 3'd1;
            PFX_HEX:   prefix_len = 3'd2;
            PFX_NIL:   prefix_len = 3'd5;
            default:   prefix_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input t_prefix p, input logic [2:0] idx);
        prefix_char = 8'h00;
        case (p)
            PFX_MINUS: prefix_char = 8'h2d;
            PFX_HEX:   prefix_char = (idx == 3'd0) ? 8'h30 : 8'h78;
            PFX_NIL: begin
                case (idx)
                    3'd0:    prefix_char = 8'h28; // (
                    3'd1:    prefix_char = 8'h6e; // n
                    3'd2:    prefix_char = 8'h69; // i
                    3'd3:    prefix_char = 8'h6c; // l
                    default: prefix_char = 8'h29; // )
                endcase
            end
            default:   prefix_char = 8'h00;
        endcase
    endfunction

endpackage

FILE: sv/i2a_digit_cell.sv
// ----------------------------------------------------------------------------
// i2a_digit_cell
// One nibble of the digit row: loads a hex nibble, runs a shift-and-add-3
// step with its neighbors, or takes the digit of its lower neighbor.
// ----------------------------------------------------------------------------
module i2a_digit_cell
    import i2a_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [3:0] i_load_nib,
    input  logic       i_carry,
    input  logic [3:0] i_shift_nib,
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    // bcd correction before the shift
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_LOAD:   r_digit <= i_load_nib;
            CELL_DABBLE: r_digit <= {w_adj[2:0], i_carry};
            CELL_SHIFT:  r_digit <= i_shift_nib;
            default:     r_digit <= r_digit;
        endcase
    end

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a value as signed/unsigned decimal, hex or pointer text, one
// character per output word, with a saturating count of characters sent.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_command, i_value
// output    out        o_valid / i_ready   o_character, o_last, o_running_count
//
// decimal: a load, 32 shift-and-add-3 steps through the 16-cell digit row,
// a shift for each skipped leading zero and a step to leave the skip,
// then the characters, a minus sign first for a negative signed value.
// hex: a load, the same skip, then the characters, 0x first for a pointer;
// a null pointer gives (nil); a stalled output adds its wait to each character.
// o_ready is high only between items; a stalled output holds the row in place.
// reset clears the sequencer, the output valid flag and the character count.
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [63:0]        i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_character,
    output logic               o_last,
    output logic [COUNT_W-1:0] o_running_count
);

    localparam int HEX_CELLS = (VALUE_WIDTH + 3) / 4;
    localparam int N_CELLS   = (HEX_CELLS > DEC_DIGITS) ? HEX_CELLS : DEC_DIGITS;
    localparam int ROW_BITS  = N_CELLS * 4;
    localparam int REM_W     = $clog2(N_CELLS + 1);
    localparam int STEP_W    = $clog2(DEC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PREFIX,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [DEC_BITS-1:0] r_bin;
    logic [STEP_W-1:0]   r_step;
    logic [REM_W-1:0]    r_rem;
    logic [2:0]          r_pidx;
    t_prefix             r_prefix;
    logic                r_upper;
    logic                r_out_valid;
    logic [7:0]          r_char;
    logic                r_last;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;

    t_cell_ctrl          w_ctrl;
    logic [ROW_BITS-1:0] w_hex_bits;
    logic [ROW_BITS-1:0] w_load_bits;
    logic [3:0]          w_digit [N_CELLS];
    logic                w_cout  [N_CELLS];
    logic [3:0]          w_top;
    logic                w_slot;
    logic                w_emit;
    logic                w_hex_mode;
    logic [DEC_BITS-1:0] w_low;

    assign w_low      = i_value[DEC_BITS-1:0];
    assign w_hex_bits = ROW_BITS'(i_value[VALUE_WIDTH-1:0]);
    assign w_hex_mode = (i_command == CMD_HEXL) || (i_command == CMD_HEXU)
                     || (i_command == CMD_PTR);
    assign w_load_bits = w_hex_mode ? w_hex_bits : '0;
    assign w_top      = w_digit[N_CELLS-1];
    assign w_slot     = !r_out_valid || i_ready;
    assign w_emit     = w_slot && ((r_state == ST_PREFIX) || (r_state == ST_EMIT));
    assign n_count    = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        w_ctrl.op = CELL_HOLD;
        case (r_state)
            ST_IDLE:  if (i_valid) w_ctrl.op = CELL_LOAD;
            ST_CONV:  w_ctrl.op = CELL_DABBLE;
            ST_SKIP:  if (w_top == 4'd0 && r_rem > REM_W'(1)) w_ctrl.op = CELL_SHIFT;
            ST_EMIT:  if (w_slot) w_ctrl.op = CELL_SHIFT;
            default:  w_ctrl.op = CELL_HOLD;
        endcase
    end

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        logic       w_cin;
        logic [3:0] w_sin;
        if (k == 0) begin : g_first
            assign w_cin = r_bin[DEC_BITS-1];
            assign w_sin = 4'd0;
        end else begin : g_rest
            assign w_cin = w_cout[k-1];
            assign w_sin = w_digit[k-1];
        end
        i2a_digit_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_nib  (w_load_bits[k*4 +: 4]),
            .i_carry     (w_cin),
            .i_shift_nib (w_sin),
            .o_digit     (w_digit[k]),
            .o_carry     (w_cout[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_emit) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_rem  <= REM_W'(N_CELLS);
                    r_pidx <= 3'd0;
                    r_step <= STEP_W'(DEC_BITS - 1);
                    if (i_valid) begin
                        case (i_command)
                            CMD_SDEC: begin
                                r_bin    <= w_low[DEC_BITS-1] ? (0 - w_low) : w_low;
                                r_prefix <= w_low[DEC_BITS-1] ? PFX_MINUS : PFX_NONE;
                                r_upper  <= 1'b0;
                                r_state  <= ST_CONV;
                            end
                            CMD_UDEC: begin
                                r_bin    <= w_low;
                                r_prefix <= PFX_NONE;
                                r_upper  <= 1'b0;
                                r_state  <= ST_CONV;
                            end
                            CMD_HEXL, CMD_HEXU: begin
                                r_prefix <= PFX_NONE;
                                r_upper  <= (i_command == CMD_HEXU);
                                r_state  <= ST_SKIP;
                            end
                            CMD_PTR: begin
                                r_upper <= 1'b0;
                                if (w_hex_bits == '0) begin
                                    r_prefix <= PFX_NIL;
                                    r_state  <= ST_PREFIX;
                                end else begin
                                    r_prefix <= PFX_HEX;
                                    r_state  <= ST_SKIP;
                                end
                            end
                            default: r_state <= ST_IDLE; // unused codes give no words
                        endcase
                    end
                end
                ST_CONV: begin
                    r_bin <= r_bin << 1;
                    if (r_step == '0) r_state <= ST_SKIP;
                    else r_step <= r_step - 1'b1;
                end
                ST_SKIP: begin
                    if (w_top != 4'd0 || r_rem == REM_W'(1)) begin
                        r_state <= (r_prefix == PFX_NONE) ? ST_EMIT : ST_PREFIX;
                    end else begin
                        r_rem <= r_rem - 1'b1;
                    end
                end
                ST_PREFIX: begin
                    if (w_slot) begin
                        r_char      <= prefix_char(r_prefix, r_pidx);
                        r_last      <= (r_prefix == PFX_NIL) && (r_pidx == 3'd4);
                        r_count     <= n_count;
                        r_pidx      <= r_pidx + 1'b1;
                        if (r_pidx == prefix_len(r_prefix) - 3'd1) begin
                            r_state <= (r_prefix == PFX_NIL) ? ST_IDLE : ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_char      <= digit_char(w_top, r_upper);
                        r_last      <= (r_rem == REM_W'(1));
                        r_count     <= n_count;
                        r_rem       <= r_rem - 1'b1;
                        if (r_rem == REM_W'(1)) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_character     = r_char;
    assign o_last          = r_last;
    assign o_running_count = r_count;

endmodule

FILE: tb/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Feeds format requests (signed and unsigned decimal, lower and upper hex,
// pointer, spare codes) through the input channel and checks every character
// word against a local model of the text and the running character count.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
    import i2a_pkg::*;

    localparam logic [2:0] CMD_FIRST_SPARE = 3'd5;
    localparam logic [2:0] CMD_MID_SPARE   = 3'd6;
    localparam logic [2:0] CMD_LAST_SPARE  = 3'd7;
    localparam int RANDOM_ITEMS   = 425;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] val;
    } t_fmt_req;

    typedef struct packed {
        logic [7:0]         ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } t_char_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_command = '0;
    logic [63:0]        i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [7:0]         o_character;
    logic               o_last;
    logic [COUNT_W-1:0] o_running_count;

    t_fmt_req           pending_reqs[$];
    t_fmt_req           next_req;
    t_char_word         expected_chars[$];
    t_char_word         want_word;
    logic [COUNT_W-1:0] chars_sent = '0;
    int                 req_total = 0;
    int                 reqs_taken = 0;
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 hold_left = 0;
    logic               hold_done = 1'b0;

    integer_to_ascii_formatter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_character     (o_character),
        .o_last          (o_last),
        .o_running_count (o_running_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // builds the text of one request and queues its words with running counts
    function automatic void format_value(input logic [2:0] cmd, input logic [63:0] val);
        logic [7:0]  txt[$];
        logic [7:0]  digs[$];
        logic [31:0] mag;
        logic [63:0] rest;
        logic [3:0]  nib;
        logic        upper;
        string       nil_txt;
        t_char_word  w;
        nil_txt = "(nil)";
        upper = (cmd == CMD_HEXU);
        case (cmd)
            CMD_SDEC, CMD_UDEC: begin
                mag = val[31:0];
                if (cmd == CMD_SDEC && mag[31]) begin
                    txt.push_back("-");
                    mag = -mag;
                end
                do begin
                    digs.push_front(8'h30 + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 0);
            end
            CMD_HEXL, CMD_HEXU, CMD_PTR: begin
                if (cmd == CMD_PTR && val == 64'd0) begin
                    foreach (nil_txt[i]) txt.push_back(nil_txt[i]);
                end else begin
                    if (cmd == CMD_PTR) begin
                        txt.push_back("0");
                        txt.push_back("x");
                    end
                    rest = val;
                    do begin
                        nib = rest[3:0];
                        if (nib < 4'd10) begin
                            digs.push_front(8'h30 + 8'(nib));
                        end else begin
                            digs.push_front((upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
                        end
                        rest = rest >> 4;
                    end while (rest != 0);
                end
            end
            default: begin
            end
        endcase
        txt = {txt, digs};
        foreach (txt[k]) begin
            if (chars_sent != COUNT_MAX) chars_sent = chars_sent + 1'b1;
            w.ch    = txt[k];
            w.last  = (k == txt.size() - 1);
            w.count = chars_sent;
            expected_chars.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_req(input logic [2:0] cmd, input logic [63:0] val);
        t_fmt_req r;
        r.cmd = cmd;
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    // phases: sender idles lightly, then heavily, then neither side idles
    function automatic int send_idle_pct();
        if (reqs_taken < req_total / 3) return 14;
        if (reqs_taken < 2 * req_total / 3) return 46;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (reqs_taken < req_total / 3) return 46;
        if (reqs_taken < 2 * req_total / 3) return 14;
        return 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                format_value(i_command, i_value);
                reqs_taken <= reqs_taken + 1;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
                next_req = pending_reqs.pop_front();
                i_valid   <= 1'b1;
                i_command <= next_req.cmd;
                i_value   <= next_req.val;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side ready, with one long hold-off midway so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= req_total / 2) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // character word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("character word with nothing expected", o_character, 64'd0);
            end else begin
                want_word = expected_chars.pop_front();
                if (o_character !== want_word.ch)
                    report_mismatch("character", o_character, want_word.ch);
                if (o_last !== want_word.last)
                    report_mismatch("last", o_last, want_word.last);
                if (o_running_count !== want_word.count)
                    report_mismatch("running_count", o_running_count, want_word.count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0] wide;
        int          useful;
        t_fmt_req    req;
        useful = 0;

        // directed: extremes of each format and the odd cases
        add_req(CMD_SDEC, 64'd0);
        add_req(CMD_SDEC, 64'd1);
        add_req(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(CMD_SDEC, 64'h0000_0000_8000_0000);
        add_req(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
        add_req(CMD_SDEC, 64'hDEAD_BEEF_0000_0005);
        add_req(CMD_UDEC, 64'd0);
        add_req(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
        add_req(CMD_UDEC, 64'hFFFF_FFFF_3B9A_CA00);
        add_req(CMD_HEXL, 64'd0);
        add_req(CMD_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(CMD_HEXL, 64'h0123_4567_89AB_CDEF);
        add_req(CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(CMD_HEXU, 64'hFEDC_BA98_7654_3210);
        add_req(CMD_HEXU, 64'h0000_0000_0000_000A);
        add_req(CMD_PTR, 64'd0);
        add_req(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(CMD_PTR, 64'd1);
        add_req(CMD_PTR, 64'h0000_0001_0000_0000);
        add_req(CMD_FIRST_SPARE, 64'h1234);
        add_req(CMD_MID_SPARE, 64'd0);
        add_req(CMD_LAST_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(CMD_SDEC, 64'h0000_0000_FFFF_FFF6);

        // random: varied magnitudes so short and long texts both show up
        while (useful < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 5) begin
                req.cmd = 3'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE));
            end else begin
                req.cmd = 3'($urandom_range(CMD_SDEC, CMD_PTR));
                useful++;
            end
            wide = {$urandom, $urandom};
            case ($urandom_range(3))
                0:       req.val = wide;
                1:       req.val = wide >> $urandom_range(63);
                2:       req.val = 64'($urandom_range(20));
                default: req.val = ~(wide >> $urandom_range(63));
            endcase
            pending_reqs.push_back(req);
        end
        req_total = pending_reqs.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_valid || expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
